// ===== hw/rtl/sth_pkg.sv =====
// Shared types, codes and the triangle test microprogram of the segment hit test.
package sth_pkg;

  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEG_START_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEG_START_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEG_START_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEG_END_X   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEG_END_Y   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEG_END_Z   = 3'd5;

  localparam logic [5:0] PROG_LAST = 6'd38;

  typedef enum logic [1:0] {MOP_MUL, MOP_MAC, MOP_MSB} mop_e;
  typedef enum logic [2:0] {A_VEC, A_C0, A_C1, A_C2, A_NUM} asel_e;
  typedef enum logic [2:0] {V_E1, V_E2, V_W0, V_W1, V_W2, V_D} vec_e;
  typedef enum logic [2:0] {D_C0, D_C1, D_C2, D_NUM, D_DEN, D_VOL, D_PRD} dst_e;
  typedef enum logic [1:0] {SG_NONE, SG_FIRST, SG_NEXT} sgm_e;

  typedef struct packed {
    vec_e       vec;
    logic [1:0] comp;
  } vsel_t;

  typedef struct packed {
    mop_e  kind;
    asel_e asel;
    vsel_t avec;
    vsel_t bvec;
    dst_e  dst;
    sgm_e  sg;
  } uop_t;

  typedef struct packed {
    logic       hold;
    logic       hold_slot;
    logic       close_tri;
    logic       mop;
    uop_t       uop;
    logic       div_start;
    logic [1:0] axis;
    logic       emit;
    logic       emit_hit;
  } cmd_t;

  typedef struct packed {
    logic       mul_busy;
    logic       div_busy;
    logic       out_free;
    logic       agree;
    logic [1:0] num_sgn;
    logic [1:0] nd_sgn;
    logic       den_nz;
  } sts_t;

  function automatic uop_t cross_uop(vec_e u, vec_e v, logic [2:0] k);
    uop_t       r;
    logic [1:0] i1;
    logic [1:0] i2;
    r      = '0;
    r.kind = k[0] ? MOP_MSB : MOP_MUL;
    r.asel = A_VEC;
    r.sg   = SG_NONE;
    unique case (k[2:1])
      2'd1: begin
        r.dst = D_C1;
        i1    = 2'd2;
        i2    = 2'd0;
      end
      2'd2: begin
        r.dst = D_C2;
        i1    = 2'd0;
        i2    = 2'd1;
      end
      default: begin
        r.dst = D_C0;
        i1    = 2'd1;
        i2    = 2'd2;
      end
    endcase
    r.avec.vec  = u;
    r.avec.comp = k[0] ? i2 : i1;
    r.bvec.vec  = v;
    r.bvec.comp = k[0] ? i1 : i2;
    return r;
  endfunction

  function automatic uop_t dot_uop(vec_e s, dst_e d, sgm_e sg, logic [1:0] k);
    uop_t r;
    r      = '0;
    r.kind = (k == 2'd0) ? MOP_MUL : MOP_MAC;
    unique case (k)
      2'd0:    r.asel = A_C0;
      2'd1:    r.asel = A_C1;
      default: r.asel = A_C2;
    endcase
    r.avec.vec  = V_D;
    r.avec.comp = k;
    r.bvec.vec  = s;
    r.bvec.comp = k;
    r.dst       = d;
    r.sg        = (k == 2'd2) ? sg : SG_NONE;
    return r;
  endfunction

  // Normal, both intercept dots, then the edge volumes W0xW1, W1xW2 and W2xW0, each dotted with D.
  function automatic uop_t prog(logic [5:0] step);
    uop_t r;
    if (step < 6'd6) begin
      r = cross_uop(V_E1, V_E2, step[2:0]);
    end else if (step < 6'd9) begin
      r = dot_uop(V_W0, D_NUM, SG_NONE, 2'(step - 6'd6));
    end else if (step < 6'd12) begin
      r = dot_uop(V_D, D_DEN, SG_NONE, 2'(step - 6'd9));
    end else if (step < 6'd18) begin
      r = cross_uop(V_W0, V_W1, 3'(step - 6'd12));
    end else if (step < 6'd21) begin
      r = dot_uop(V_D, D_VOL, SG_FIRST, 2'(step - 6'd18));
    end else if (step < 6'd27) begin
      r = cross_uop(V_W1, V_W2, 3'(step - 6'd21));
    end else if (step < 6'd30) begin
      r = dot_uop(V_D, D_VOL, SG_NEXT, 2'(step - 6'd27));
    end else if (step < 6'd36) begin
      r = cross_uop(V_W2, V_W0, 3'(step - 6'd30));
    end else begin
      r = dot_uop(V_D, D_VOL, SG_NEXT, 2'(step - 6'd36));
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/sth_if.sv =====
// Handshake interfaces for vertex words, result words and configuration writes.
interface sth_vtx_if #(parameter int unsigned COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] vertex_z;
  logic                         last_vertex;
  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface sth_res_if #(parameter int unsigned COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  modport source (output valid, hit, point_x, point_y, point_z, input ready);
  modport sink (input valid, hit, point_x, point_y, point_z, output ready);
endinterface

interface sth_cfg_if #(parameter int unsigned COORD_BITS = 32);
  logic                                  valid;
  logic                                  ready;
  logic [sth_pkg::CFG_IDX_BITS-1:0]      index;
  logic [COORD_BITS-1:0]                 data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/sth_ctrl.sv =====
// Controller state machine that sequences vertex capture, the triangle program and output.
module sth_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output sth_pkg::cmd_t cmd_o,
  input  sth_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_MWAIT, S_QMUL, S_QMWAIT, S_DIV, S_DWAIT, S_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       hr_q, hr_d;
  logic       last_q, last_d;
  logic [5:0] step_q, step_d;
  logic [1:0] ax_q, ax_d;
  logic       ehit_q, ehit_d;
  logic       tri_hit;

  assign tri_hit = sts_i.agree && (sts_i.num_sgn != sts_i.nd_sgn) && sts_i.den_nz;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    hr_d      = hr_q;
    last_d    = last_q;
    step_d    = step_q;
    ax_d      = ax_q;
    ehit_d    = ehit_q;
    cmd_o     = '0;
    cmd_o.uop = sth_pkg::prog(step_q);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (phase_q < 2'd2) begin
            cmd_o.hold      = 1'b1;
            cmd_o.hold_slot = phase_q[0];
            phase_d         = in_last_i ? 2'd0 : phase_q + 2'd1;
            if (in_last_i) begin
              hr_d = 1'b0;
              if (!hr_q) begin
                ehit_d  = 1'b0;
                state_d = S_EMIT;
              end
            end
          end else begin
            phase_d = 2'd0;
            if (hr_q) begin
              if (in_last_i) begin
                hr_d = 1'b0;
              end
            end else begin
              cmd_o.close_tri = 1'b1;
              last_d          = in_last_i;
              step_d          = 6'd0;
              state_d         = S_MUL;
            end
          end
        end
      end
      S_MUL: begin
        cmd_o.mop = 1'b1;
        state_d   = S_MWAIT;
      end
      S_MWAIT: begin
        if (!sts_i.mul_busy) begin
          if (step_q == sth_pkg::PROG_LAST) begin
            if (tri_hit) begin
              ax_d    = 2'd0;
              state_d = S_QMUL;
            end else if (last_q) begin
              ehit_d  = 1'b0;
              state_d = S_EMIT;
            end else begin
              state_d = S_IDLE;
            end
          end else begin
            step_d  = step_q + 6'd1;
            state_d = S_MUL;
          end
        end
      end
      S_QMUL: begin
        cmd_o.mop            = 1'b1;
        cmd_o.uop.kind       = sth_pkg::MOP_MUL;
        cmd_o.uop.asel       = sth_pkg::A_NUM;
        cmd_o.uop.avec.vec   = sth_pkg::V_D;
        cmd_o.uop.avec.comp  = ax_q;
        cmd_o.uop.bvec.vec   = sth_pkg::V_D;
        cmd_o.uop.bvec.comp  = ax_q;
        cmd_o.uop.dst        = sth_pkg::D_PRD;
        cmd_o.uop.sg         = sth_pkg::SG_NONE;
        state_d              = S_QMWAIT;
      end
      S_QMWAIT: begin
        if (!sts_i.mul_busy) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.axis      = ax_q;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (!sts_i.div_busy) begin
          if (ax_q == 2'd2) begin
            hr_d    = !last_q;
            ehit_d  = 1'b1;
            state_d = S_EMIT;
          end else begin
            ax_d    = ax_q + 2'd1;
            state_d = S_QMUL;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_hit = ehit_q;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= 2'd0;
      hr_q    <= 1'b0;
      last_q  <= 1'b0;
      step_q  <= 6'd0;
      ax_q    <= 2'd0;
      ehit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      hr_q    <= hr_d;
      last_q  <= last_d;
      step_q  <= step_d;
      ax_q    <= ax_d;
      ehit_q  <= ehit_d;
    end
  end

endmodule

// ===== hw/rtl/sth_dp.sv =====
// Datapath: segment and vertex registers, serial multiplier, serial divider, output word.
module sth_dp #(
  parameter int unsigned CB = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sth_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CB-1:0]                    cfg_data_i,
  input  logic [CB-1:0]                    vx_i,
  input  logic [CB-1:0]                    vy_i,
  input  logic [CB-1:0]                    vz_i,
  input  sth_pkg::cmd_t                    cmd_i,
  output sth_pkg::sts_t                    sts_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic                             res_hit_o,
  output logic [CB-1:0]                    res_px_o,
  output logic [CB-1:0]                    res_py_o,
  output logic [CB-1:0]                    res_pz_o
);

  localparam int unsigned NW  = CB + 1;
  localparam int unsigned XW  = 4 * CB + 8;
  localparam int unsigned MCW = $clog2(NW);
  localparam int unsigned DCW = $clog2(XW);

  logic [2:0][CB-1:0] a_q, b_q, p0_q, p1_q, p2_q, pt_q;
  logic [XW-1:0]      c0_q, c1_q, c2_q, num_q, den_q, vol_q, prd_q;

  logic               mbusy_q;
  logic [MCW-1:0]     mcnt_q;
  logic [XW-1:0]      ma_q, macc_q;
  logic [NW-1:0]      mb_q;
  sth_pkg::mop_e      mkind_q;
  sth_pkg::dst_e      mdst_q;
  sth_pkg::sgm_e      msg_q;
  logic [1:0]         sfirst_q;
  logic               agree_q;

  logic               dbusy_q;
  logic [DCW-1:0]     dcnt_q;
  logic [XW-1:0]      dvd_q, dsr_q, drem_q, dq_q;
  logic               dneg_q;
  logic [1:0]         dax_q;

  logic               ovalid_q;
  logic               ohit_q;
  logic [2:0][CB-1:0] opt_q;

  logic [NW-1:0]      aval, bval;
  logic [XW-1:0]      aop, mterm, mprod, mcur, mres, numden;
  logic [1:0]         rsgn;
  logic [XW:0]        rsh;
  logic               dge;
  logic [XW-1:0]      drem_d, qf;
  logic               big;
  logic [CB:0]        qc;
  logic [CB+1:0]      qs, psum;
  logic [CB-1:0]      av, pnew;

  function automatic logic [NW-1:0] vec_val(sth_pkg::vsel_t s,
                                            logic [2:0][CB-1:0] p0, logic [2:0][CB-1:0] p1,
                                            logic [2:0][CB-1:0] p2, logic [2:0][CB-1:0] sa,
                                            logic [2:0][CB-1:0] sb);
    logic [CB-1:0] m;
    logic [CB-1:0] n;
    unique case (s.vec)
      sth_pkg::V_E1: begin m = p1[s.comp]; n = p0[s.comp]; end
      sth_pkg::V_E2: begin m = p2[s.comp]; n = p0[s.comp]; end
      sth_pkg::V_W0: begin m = p0[s.comp]; n = sa[s.comp]; end
      sth_pkg::V_W1: begin m = p1[s.comp]; n = sa[s.comp]; end
      sth_pkg::V_W2: begin m = p2[s.comp]; n = sa[s.comp]; end
      sth_pkg::V_D:  begin m = sb[s.comp]; n = sa[s.comp]; end
      default:       begin m = '0;         n = '0;         end
    endcase
    return {m[CB-1], m} - {n[CB-1], n};
  endfunction

  function automatic logic [1:0] sgn(logic [XW-1:0] x);
    return {x[XW-1], |x};
  endfunction

  always_comb begin
    aval = vec_val(cmd_i.uop.avec, p0_q, p1_q, p2_q, a_q, b_q);
    bval = vec_val(cmd_i.uop.bvec, p0_q, p1_q, p2_q, a_q, b_q);
    unique case (cmd_i.uop.asel)
      sth_pkg::A_C0:  aop = c0_q;
      sth_pkg::A_C1:  aop = c1_q;
      sth_pkg::A_C2:  aop = c2_q;
      sth_pkg::A_NUM: aop = num_q;
      default:        aop = {{(XW-NW){aval[NW-1]}}, aval};
    endcase
  end

  // Signed multiplier, one bit of the narrow operand per cycle, most significant first.
  always_comb begin
    if (mb_q[NW-1]) begin
      mterm = (mcnt_q == MCW'(NW - 1)) ? -ma_q : ma_q;
    end else begin
      mterm = '0;
    end
    mprod = {macc_q[XW-2:0], 1'b0} + mterm;
    unique case (mdst_q)
      sth_pkg::D_C0:  mcur = c0_q;
      sth_pkg::D_C1:  mcur = c1_q;
      sth_pkg::D_C2:  mcur = c2_q;
      sth_pkg::D_NUM: mcur = num_q;
      sth_pkg::D_DEN: mcur = den_q;
      sth_pkg::D_VOL: mcur = vol_q;
      sth_pkg::D_PRD: mcur = prd_q;
      default:        mcur = '0;
    endcase
    unique case (mkind_q)
      sth_pkg::MOP_MAC: mres = mcur + mprod;
      sth_pkg::MOP_MSB: mres = mcur - mprod;
      default:          mres = mprod;
    endcase
    rsgn   = sgn(mres);
    numden = num_q - den_q;
  end

  // Restoring divider on magnitudes; the last step also forms the saturated point.
  always_comb begin
    rsh    = {drem_q, dvd_q[XW-1]};
    dge    = (rsh >= {1'b0, dsr_q});
    drem_d = dge ? XW'(rsh - {1'b0, dsr_q}) : rsh[XW-1:0];
    qf     = {dq_q[XW-2:0], dge};
    big    = |qf[XW-1:CB];
    qc     = big ? {1'b1, {CB{1'b0}}} : {1'b0, qf[CB-1:0]};
    qs     = dneg_q ? -{1'b0, qc} : {1'b0, qc};
    av     = a_q[dax_q];
    psum   = {{2{av[CB-1]}}, av} + qs;
    if ((psum[CB+1:CB-1] == 3'b000) || (psum[CB+1:CB-1] == 3'b111)) begin
      pnew = psum[CB-1:0];
    end else if (psum[CB+1]) begin
      pnew = {1'b1, {(CB-1){1'b0}}};
    end else begin
      pnew = {1'b0, {(CB-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q      <= '0;
      b_q      <= '0;
      mbusy_q  <= 1'b0;
      mcnt_q   <= '0;
      dbusy_q  <= 1'b0;
      dcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sth_pkg::CFG_SEG_START_X: a_q[0] <= cfg_data_i;
          sth_pkg::CFG_SEG_START_Y: a_q[1] <= cfg_data_i;
          sth_pkg::CFG_SEG_START_Z: a_q[2] <= cfg_data_i;
          sth_pkg::CFG_SEG_END_X:   b_q[0] <= cfg_data_i;
          sth_pkg::CFG_SEG_END_Y:   b_q[1] <= cfg_data_i;
          sth_pkg::CFG_SEG_END_Z:   b_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.mop) begin
        mbusy_q <= 1'b1;
        mcnt_q  <= MCW'(NW - 1);
      end else if (mbusy_q) begin
        mcnt_q <= mcnt_q - 1'b1;
        if (mcnt_q == '0) begin
          mbusy_q <= 1'b0;
        end
      end
      if (cmd_i.div_start) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= DCW'(XW - 1);
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q - 1'b1;
        if (dcnt_q == '0) begin
          dbusy_q <= 1'b0;
        end
      end
      if (cmd_i.emit) begin
        ovalid_q <= 1'b1;
      end else if (res_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold) begin
      if (cmd_i.hold_slot) begin
        p1_q <= {vz_i, vy_i, vx_i};
      end else begin
        p0_q <= {vz_i, vy_i, vx_i};
      end
    end
    if (cmd_i.close_tri) begin
      p2_q <= {vz_i, vy_i, vx_i};
    end
    if (cmd_i.mop) begin
      ma_q    <= aop;
      mb_q    <= bval;
      macc_q  <= '0;
      mkind_q <= cmd_i.uop.kind;
      mdst_q  <= cmd_i.uop.dst;
      msg_q   <= cmd_i.uop.sg;
    end else if (mbusy_q) begin
      macc_q <= mprod;
      mb_q   <= {mb_q[NW-2:0], 1'b0};
      if (mcnt_q == '0) begin
        unique case (mdst_q)
          sth_pkg::D_C0:  c0_q  <= mres;
          sth_pkg::D_C1:  c1_q  <= mres;
          sth_pkg::D_C2:  c2_q  <= mres;
          sth_pkg::D_NUM: num_q <= mres;
          sth_pkg::D_DEN: den_q <= mres;
          sth_pkg::D_VOL: vol_q <= mres;
          sth_pkg::D_PRD: prd_q <= mres;
          default: ;
        endcase
        unique case (msg_q)
          sth_pkg::SG_FIRST: begin
            sfirst_q <= rsgn;
            agree_q  <= 1'b1;
          end
          sth_pkg::SG_NEXT: agree_q <= agree_q && (rsgn == sfirst_q);
          default: ;
        endcase
      end
    end
    if (cmd_i.div_start) begin
      dvd_q  <= prd_q[XW-1] ? -prd_q : prd_q;
      dsr_q  <= den_q[XW-1] ? -den_q : den_q;
      drem_q <= '0;
      dq_q   <= '0;
      dneg_q <= prd_q[XW-1] ^ den_q[XW-1];
      dax_q  <= cmd_i.axis;
    end else if (dbusy_q) begin
      drem_q <= drem_d;
      dq_q   <= qf;
      dvd_q  <= {dvd_q[XW-2:0], 1'b0};
      if (dcnt_q == '0) begin
        pt_q[dax_q] <= pnew;
      end
    end
    if (cmd_i.emit) begin
      ohit_q <= cmd_i.emit_hit;
      opt_q  <= cmd_i.emit_hit ? pt_q : '0;
    end
  end

  assign sts_o.mul_busy = mbusy_q;
  assign sts_o.div_busy = dbusy_q;
  assign sts_o.out_free = !ovalid_q || res_ready_i;
  assign sts_o.agree    = agree_q;
  assign sts_o.num_sgn  = sgn(num_q);
  assign sts_o.nd_sgn   = sgn(numden);
  assign sts_o.den_nz   = |den_q;

  assign res_valid_o = ovalid_q;
  assign res_hit_o   = ohit_q;
  assign res_px_o    = opt_q[0];
  assign res_py_o    = opt_q[1];
  assign res_pz_o    = opt_q[2];

endmodule

// ===== hw/rtl/segment_triangle_hit_test.sv =====
// Top level of the segment / triangle hit test over a streamed mesh.
// A vertex that opens or extends a triangle is only held; when it ends a query with no hit, a miss word is emitted.
// A closing vertex runs 39 serial products unless the query has already reported a hit.
// A hit adds three products and three divisions.
// A result word is loaded into the output register; a full output register stalls the vertex input.
// Reset is asynchronous and clears the segment, the vertex phase and the hit flag.
module segment_triangle_hit_test #(
  parameter int unsigned COORD_BITS = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  sth_vtx_if.sink   vtx_i,
  sth_res_if.source res_o,
  sth_cfg_if.sink   cfg_i
);

  sth_pkg::cmd_t cmd;
  sth_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  sth_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vtx_i.valid),
    .in_last_i  (vtx_i.last_vertex),
    .in_ready_o (vtx_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  sth_dp #(.CB(COORD_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .vx_i        (vtx_i.vertex_x),
    .vy_i        (vtx_i.vertex_y),
    .vz_i        (vtx_i.vertex_z),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_hit_o   (res_o.hit),
    .res_px_o    (res_o.point_x),
    .res_py_o    (res_o.point_y),
    .res_pz_o    (res_o.point_z)
  );

endmodule

// ===== bench/sth_hit_checker.sv =====
// Watches the vertex, result and configuration channels, predicts each result and compares it.
module sth_hit_checker #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sth_vtx_if        vtx_mon,
  sth_res_if        res_mon,
  sth_cfg_if        cfg_mon,
  output int        mismatches_o,
  output int        pending_o
);

  typedef logic signed [191:0] wide_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    logic   hit;
    coord_t px;
    coord_t py;
    coord_t pz;
  } hit_word_t;

  coord_t    seg_a [3];
  coord_t    seg_b [3];
  coord_t    held [6];
  int        phase;
  bit        reported;
  hit_word_t hit_words_q [$];
  int        mismatches;
  int        pending = 0;

  assign mismatches_o = mismatches;
  assign pending_o    = pending;

  function automatic wide_t triple(wide_t u[3], wide_t v[3], wide_t s[3]);
    wide_t c0;
    wide_t c1;
    wide_t c2;
    c0 = u[1] * v[2] - u[2] * v[1];
    c1 = u[2] * v[0] - u[0] * v[2];
    c2 = u[0] * v[1] - u[1] * v[0];
    return c0 * s[0] + c1 * s[1] + c2 * s[2];
  endfunction

  function automatic int sgn(wide_t w);
    return (w < 0) ? -1 : ((w == 0) ? 0 : 1);
  endfunction

  function automatic int volume_sign(wide_t a[3], wide_t b[3], wide_t c[3], wide_t d[3]);
    wide_t u[3];
    wide_t v[3];
    wide_t s[3];
    for (int i = 0; i < 3; i++) begin
      u[i] = b[i] - a[i];
      v[i] = c[i] - a[i];
      s[i] = d[i] - a[i];
    end
    return sgn(triple(u, v, s));
  endfunction

  function automatic bit crossing_point(wide_t a[3], wide_t b[3], wide_t p0[3],
                                        wide_t p1[3], wide_t p2[3], output coord_t pt[3]);
    wide_t e1[3];
    wide_t e2[3];
    wide_t ba[3];
    wide_t pa[3];
    wide_t num;
    wide_t den;
    wide_t sum;
    wide_t hi;
    int    s3;
    int    s4;
    int    s5;
    hi = (wide_t'(1) <<< (COORD_BITS - 1)) - 1;
    for (int i = 0; i < 3; i++) pt[i] = '0;
    if (volume_sign(a, p0, p1, p2) == volume_sign(b, p0, p1, p2)) return 1'b0;
    s3 = volume_sign(a, b, p0, p1);
    s4 = volume_sign(a, b, p1, p2);
    s5 = volume_sign(a, b, p2, p0);
    if (s3 != s4 || s4 != s5) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = p1[i] - p0[i];
      e2[i] = p2[i] - p0[i];
      ba[i] = b[i] - a[i];
      pa[i] = p0[i] - a[i];
    end
    num = triple(e1, e2, pa);
    den = triple(e1, e2, ba);
    if (den == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum = a[i] + (num * ba[i]) / den;
      if (sum > hi) sum = hi;
      if (sum < -hi - 1) sum = -hi - 1;
      pt[i] = coord_t'(sum);
    end
    return 1'b1;
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic take_vertex(coord_t x, coord_t y, coord_t z, logic last);
    wide_t     a[3];
    wide_t     b[3];
    wide_t     p0[3];
    wide_t     p1[3];
    wide_t     p2[3];
    coord_t    pt[3];
    hit_word_t w;
    bit        made;
    made = 1'b0;
    if (phase < 2) begin
      held[phase*3]   = x;
      held[phase*3+1] = y;
      held[phase*3+2] = z;
      phase++;
    end else begin
      phase = 0;
      if (!reported) begin
        for (int i = 0; i < 3; i++) begin
          a[i]  = seg_a[i];
          b[i]  = seg_b[i];
          p0[i] = held[i];
          p1[i] = held[3+i];
        end
        p2[0] = x;
        p2[1] = y;
        p2[2] = z;
        if (crossing_point(a, b, p0, p1, p2, pt)) begin
          w.hit = 1'b1;
          w.px  = pt[0];
          w.py  = pt[1];
          w.pz  = pt[2];
          hit_words_q.push_back(w);
          reported = 1'b1;
          made = 1'b1;
        end
      end
    end
    if (last) begin
      if (!made && !reported) begin
        w.hit = 1'b0;
        w.px  = '0;
        w.py  = '0;
        w.pz  = '0;
        hit_words_q.push_back(w);
      end
      phase = 0;
      reported = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hit_word_t w;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        seg_a[i] = '0;
        seg_b[i] = '0;
      end
      phase = 0;
      reported = 1'b0;
      pending = hit_words_q.size();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (hit_words_q.size() == 0) begin
          report("result word with none expected");
        end else begin
          w = hit_words_q.pop_front();
          if (res_mon.hit !== w.hit) begin
            report($sformatf("hit got %h expected %h", res_mon.hit, w.hit));
          end
          if (res_mon.point_x !== w.px) begin
            report($sformatf("point_x got %h expected %h", res_mon.point_x, w.px));
          end
          if (res_mon.point_y !== w.py) begin
            report($sformatf("point_y got %h expected %h", res_mon.point_y, w.py));
          end
          if (res_mon.point_z !== w.pz) begin
            report($sformatf("point_z got %h expected %h", res_mon.point_z, w.pz));
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          sth_pkg::CFG_SEG_START_X: seg_a[0] = cfg_mon.data;
          sth_pkg::CFG_SEG_START_Y: seg_a[1] = cfg_mon.data;
          sth_pkg::CFG_SEG_START_Z: seg_a[2] = cfg_mon.data;
          sth_pkg::CFG_SEG_END_X:   seg_b[0] = cfg_mon.data;
          sth_pkg::CFG_SEG_END_Y:   seg_b[1] = cfg_mon.data;
          sth_pkg::CFG_SEG_END_Z:   seg_b[2] = cfg_mon.data;
          default: ;
        endcase
      end
      if (vtx_mon.valid && vtx_mon.ready) begin
        take_vertex(vtx_mon.vertex_x, vtx_mon.vertex_y, vtx_mon.vertex_z, vtx_mon.last_vertex);
      end
      pending = hit_words_q.size();
    end
  end

  initial mismatches = 0;

endmodule

// ===== bench/tb_segment_triangle_hit_test.sv =====
// Testbench top: drives vertex meshes and segment settings, stalls the result side, and gives the verdict.
module tb_segment_triangle_hit_test;

  localparam int unsigned CW = 32;
  localparam int LIMIT = 4000000;
  localparam int SETTLE = 2500;
  localparam logic signed [CW-1:0] CMAX = 32'sh7fffffff;
  localparam logic signed [CW-1:0] CMIN = 32'sh80000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   mismatches;
  int   pending;
  int   cycles = 0;
  int   burst_left = 0;
  int   hold_cycles = 0;
  bit   long_hold = 1'b0;
  int   stall_mode = 0;
  logic signed [CW-1:0] mid [3];

  sth_vtx_if #(CW) vtx ();
  sth_res_if #(CW) res ();
  sth_cfg_if #(CW) cfg ();

  segment_triangle_hit_test #(.COORD_BITS(CW)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .vtx_i(vtx), .res_o(res), .cfg_i(cfg)
  );

  sth_hit_checker #(.COORD_BITS(CW)) chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .vtx_mon(vtx), .res_mon(res), .cfg_mon(cfg),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_segment_triangle_hit_test: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (long_hold) begin
      long_hold = 1'b0;
      hold_cycles = 3000;
    end
    if (cycles % 200 == 0) stall_mode = $urandom_range(0, 2);
    if (hold_cycles > 0) begin
      hold_cycles--;
      res.ready <= 1'b0;
    end else if (stall_mode == 0) begin
      res.ready <= 1'b1;
    end else if (stall_mode == 1) begin
      res.ready <= ($urandom_range(0, 1) != 0);
    end else begin
      res.ready <= ($urandom_range(0, 9) != 0);
    end
  end

  task automatic send_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                             logic signed [CW-1:0] z, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if (gap > 0) begin
        @(negedge clk_i);
        vtx.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk_i);
    vtx.valid       <= 1'b1;
    vtx.vertex_x    <= x;
    vtx.vertex_y    <= y;
    vtx.vertex_z    <= z;
    vtx.last_vertex <= last;
    @(posedge clk_i);
    while (!vtx.ready) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sth_pkg::CFG_IDX_BITS-1:0] idx, logic [CW-1:0] value);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    vtx.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_segment(logic signed [CW-1:0] a[3], logic signed [CW-1:0] b[3]);
    logic signed [CW:0] s;
    write_reg(sth_pkg::CFG_SEG_START_X, a[0]);
    write_reg(sth_pkg::CFG_SEG_START_Y, a[1]);
    write_reg(sth_pkg::CFG_SEG_START_Z, a[2]);
    write_reg(sth_pkg::CFG_SEG_END_X, b[0]);
    write_reg(sth_pkg::CFG_SEG_END_Y, b[1]);
    write_reg(sth_pkg::CFG_SEG_END_Z, b[2]);
    for (int i = 0; i < 3; i++) begin
      s = (33'(a[i]) + 33'(b[i])) >>> 1;
      mid[i] = s[CW-1:0];
    end
  endtask

  function automatic logic signed [CW-1:0] pick_coord(int k);
    int mode;
    mode = $urandom_range(0, 19);
    if (mode == 0) return $urandom;
    if (mode == 1) return ($urandom_range(0, 1) != 0) ? CMAX : CMIN;
    return mid[k] + $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
  endfunction

  task automatic random_meshes(int count);
    int left;
    int len;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 3 * $urandom_range(1, 4);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        send_vertex(pick_coord(0), pick_coord(1), pick_coord(2), i == len - 1);
      end
      left -= len;
    end
  endtask

  initial begin
    logic signed [CW-1:0] a[3];
    logic signed [CW-1:0] b[3];
    vtx.valid = 1'b0;
    vtx.vertex_x = '0;
    vtx.vertex_y = '0;
    vtx.vertex_z = '0;
    vtx.last_vertex = 1'b0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = sth_pkg::CFG_SEG_START_X;
    cfg.data = '0;
    for (int i = 0; i < 3; i++) mid[i] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    random_meshes(12);
    drain();

    a = '{32'sh4000, 32'sh8000, -(32'sh80000)};
    b = '{32'sh1999, -(32'sh3333), 32'sh80000};
    set_segment(a, b);
    send_vertex(-(32'sh20000), -(32'sh20000), 32'sh0, 1'b0);
    send_vertex(32'sh20000, -(32'sh20000), 32'sh10000, 1'b0);
    send_vertex(32'sh0, 32'sh20000, -(32'sh10000), 1'b0);
    send_vertex(-(32'sh20000), -(32'sh20000), 32'sh0, 1'b0);
    send_vertex(32'sh20000, -(32'sh20000), 32'sh10000, 1'b0);
    send_vertex(32'sh0, 32'sh20000, -(32'sh10000), 1'b1);
    send_vertex(CMAX, CMAX, CMAX, 1'b1);
    send_vertex(CMIN, CMIN, CMIN, 1'b0);
    send_vertex(CMAX, CMIN, CMAX, 1'b0);
    send_vertex(CMIN, CMAX, CMAX, 1'b1);
    send_vertex(32'sh10000, 32'sh10000, 32'sh10000, 1'b0);
    send_vertex(32'sh10000, 32'sh10000, 32'sh10000, 1'b0);
    send_vertex(32'sh10000, 32'sh10000, 32'sh10000, 1'b0);
    send_vertex(32'sh4000, -(32'sh10000), -(32'sh10000), 1'b0);
    send_vertex(32'sh4000, 32'sh10000, -(32'sh10000), 1'b0);
    send_vertex(32'sh4000, 32'sh0, 32'sh10000, 1'b0);
    send_vertex(-(32'sh20000), -(32'sh20000), 32'sh0, 1'b0);
    send_vertex(32'sh20000, -(32'sh20000), 32'sh0, 1'b1);
    send_vertex(-(32'sh20000), -(32'sh20000), 32'sh0, 1'b0);
    send_vertex(32'sh20000, -(32'sh20000), 32'sh10000, 1'b0);
    send_vertex(32'sh0, 32'sh20000, -(32'sh10000), 1'b1);
    random_meshes(100);
    drain();

    a = '{CMIN, CMIN, CMIN};
    b = '{CMAX, CMAX, CMAX};
    set_segment(a, b);
    random_meshes(110);
    drain();

    for (int i = 0; i < 3; i++) begin
      a[i] = $signed($urandom_range(0, 32'h100000)) - 32'sh80000;
      b[i] = $signed($urandom_range(0, 32'h100000)) - 32'sh80000;
    end
    set_segment(a, b);
    long_hold = 1'b1;
    random_meshes(110);
    drain();

    a = '{CMAX, 32'sh0, CMIN};
    b = '{CMIN, 32'sh0, CMAX};
    set_segment(a, b);
    random_meshes(110);
    drain();

    for (int p = 0; p < 2; p++) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = $urandom;
        b[i] = $urandom;
      end
      set_segment(a, b);
      random_meshes(110);
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("tb_segment_triangle_hit_test: PASS");
    end else begin
      $display("tb_segment_triangle_hit_test: FAIL");
    end
    $finish;
  end

endmodule
